// ----- sv/cau_pkg.sv -----
package cau_pkg;

    localparam int DW  = 32;         // data width of every operand part
    localparam int FB  = 16;         // fraction bits
    localparam int PW  = 2 * DW;     // product width
    localparam int SW  = PW + 1;     // sum of two products
    localparam int NW  = PW + FB;    // scaled dividend magnitude
    localparam int QB  = DW + 1;     // quotient bits, top bit flags overflow
    localparam int CW  = PW + QB;    // shifted divisor compare width
    localparam int QD  = 4;          // depth of the front-to-back queue
    localparam int QAW = $clog2(QD);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CNJ = 3'd4;
    localparam logic [2:0] OP_SQM = 3'd5;
    localparam logic [2:0] OP_EQ  = 3'd6;

    localparam logic signed [SW-1:0] SMAX_W = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN_W = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    // classified transaction as it waits in the queue
    typedef struct packed {
        logic [2:0]           op;
        logic                 eq;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
    } t_item;

    // clip a wide value to the data range, flag in the top bit
    function automatic logic [DW:0] sat_w(input logic signed [SW-1:0] v);
        logic [DW:0] r;
        if (v > SMAX_W) begin
            r = {1'b1, 1'b0, {(DW-1){1'b1}}};
        end else if (v < SMIN_W) begin
            r = {1'b1, 1'b1, {(DW-1){1'b0}}};
        end else begin
            r = {1'b0, v[DW-1:0]};
        end
        return r;
    endfunction

endpackage

// ----- sv/complex_arithmetic_unit.sv -----
// throughput: one transaction per cycle while the output register is free or being popped;
// the divider is fully pipelined, one quotient bit of each part per stage over 33 stages,
// and every operation runs through the same pipe
// a result waits in the output register while the 4-entry queue keeps taking pushes
// reset: synchronous active low, clears queue pointers and all pipeline valid bits
module complex_arithmetic_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [2:0]                    i_req_type,
    input  logic signed [cau_pkg::DW-1:0] i_a_real,
    input  logic signed [cau_pkg::DW-1:0] i_a_imag,
    input  logic signed [cau_pkg::DW-1:0] i_b_real,
    input  logic signed [cau_pkg::DW-1:0] i_b_imag,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic signed [cau_pkg::DW-1:0] o_res_real,
    output logic signed [cau_pkg::DW-1:0] o_res_imag,
    output logic                          o_is_equal,
    output logic                          o_saturated,
    output logic                          o_div_by_zero
);
    import cau_pkg::*;

    // front: classify the transaction and settle equality
    t_item front_item;
    t_item q_item;
    logic  q_empty;
    logic  back_take;

    cau_front u_front (
        .i_req_type (i_req_type),
        .i_a_real   (i_a_real),
        .i_a_imag   (i_a_imag),
        .i_b_real   (i_b_real),
        .i_b_imag   (i_b_imag),
        .o_item     (front_item)
    );

    // short queue decouples acceptance from the arithmetic pipe
    cau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (front_item),
        .o_full  (o_full),
        .i_pop   (back_take),
        .o_empty (q_empty),
        .o_data  (q_item)
    );

    // back: multipliers, sums with saturation, pipelined divider, output register
    cau_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!q_empty),
        .i_item        (q_item),
        .o_take        (back_take),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_res_real    (o_res_real),
        .o_res_imag    (o_res_imag),
        .o_is_equal    (o_is_equal),
        .o_saturated   (o_saturated),
        .o_div_by_zero (o_div_by_zero)
    );

endmodule

// ----- sv/cau_front.sv -----
module cau_front (
    input  logic [2:0]                  i_req_type,
    input  logic signed [cau_pkg::DW-1:0] i_a_real,
    input  logic signed [cau_pkg::DW-1:0] i_a_imag,
    input  logic signed [cau_pkg::DW-1:0] i_b_real,
    input  logic signed [cau_pkg::DW-1:0] i_b_imag,
    output cau_pkg::t_item              o_item
);
    import cau_pkg::*;

    // equality is settled here, the back only carries the flag
    always_comb begin
        o_item.op = i_req_type;
        o_item.eq = (i_req_type == OP_EQ) && (i_a_real == i_b_real) && (i_a_imag == i_b_imag);
        o_item.ar = i_a_real;
        o_item.ai = i_a_imag;
        o_item.br = i_b_real;
        o_item.bi = i_b_imag;
    end

endmodule

// ----- sv/cau_fifo.sv -----
module cau_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cau_pkg::t_item i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output cau_pkg::t_item o_data
);
    import cau_pkg::*;

    t_item            r_mem [QD];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == (QAW+1)'(QD));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(wr) - (QAW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

// ----- sv/cau_back.sv -----
module cau_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  cau_pkg::t_item                i_item,
    output logic                          o_take,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic signed [cau_pkg::DW-1:0] o_res_real,
    output logic signed [cau_pkg::DW-1:0] o_res_imag,
    output logic                          o_is_equal,
    output logic                          o_saturated,
    output logic                          o_div_by_zero
);
    import cau_pkg::*;

    typedef struct packed {
        logic [2:0]           op;
        logic                 eq;
        logic signed [DW-1:0] ar, ai, br, bi;
        logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
    } t_mul;

    typedef struct packed {
        logic                 isdiv;
        logic signed [DW-1:0] re, im;
        logic                 eq, sf, dz;
        logic                 negr, negi;
        logic [NW-1:0]        rr, ri;
        logic [PW-1:0]        d;
        logic [QB-1:0]        qr, qi;
    } t_ds;

    function automatic logic signed [SW-1:0] sx(input logic signed [DW-1:0] v);
        return {{(SW-DW){v[DW-1]}}, v};
    endfunction

    function automatic logic signed [SW-1:0] px(input logic signed [PW-1:0] v);
        return {v[PW-1], v};
    endfunction

    // quotient magnitude and sign to a clipped result, flag on top
    function automatic logic [DW:0] fin(input logic [QB-1:0] q, input logic neg);
        logic [DW:0] r;
        logic [QB-1:0] nq;
        nq = -q;
        if (!neg) begin
            if (q > {2'b00, {(DW-1){1'b1}}}) r = {1'b1, 1'b0, {(DW-1){1'b1}}};
            else r = {1'b0, q[DW-1:0]};
        end else begin
            if (q > {2'b01, {(DW-1){1'b0}}}) r = {1'b1, 1'b1, {(DW-1){1'b0}}};
            else r = {1'b0, nq[DW-1:0]};
        end
        return r;
    endfunction

    logic                 adv;
    logic                 r_mv;
    t_mul                 r_m;
    logic [QB:0]          r_dv;
    t_ds                  r_ds [QB+1];
    logic                 r_fv;
    logic signed [DW-1:0] r_fre, r_fim;
    logic                 r_feq, r_fsf, r_fdz;

    // whole pipe moves while the output slot is free or being taken
    assign adv    = !r_fv || i_pop;
    assign o_take = adv && i_valid;

    // multiply stage
    logic signed [DW-1:0] m4a, m5a;
    assign m4a = (i_item.op == OP_SQM) ? i_item.ar : i_item.br;
    assign m5a = (i_item.op == OP_SQM) ? i_item.ai : i_item.bi;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m.op <= i_item.op;
            r_m.eq <= i_item.eq;
            r_m.ar <= i_item.ar;
            r_m.ai <= i_item.ai;
            r_m.br <= i_item.br;
            r_m.bi <= i_item.bi;
            r_m.p0 <= PW'(i_item.ar) * PW'(i_item.br);
            r_m.p1 <= PW'(i_item.ai) * PW'(i_item.bi);
            r_m.p2 <= PW'(i_item.ai) * PW'(i_item.br);
            r_m.p3 <= PW'(i_item.ar) * PW'(i_item.bi);
            r_m.p4 <= PW'(m4a) * PW'(m4a);
            r_m.p5 <= PW'(m5a) * PW'(m5a);
        end
    end

    // sum stage: finishes every operation but divide
    t_ds                  s_n;
    logic signed [SW-1:0] nre, nim, t0, t1;
    logic [DW:0]          sr, si;

    always_comb begin
        s_n = '0;
        nre = '0;
        nim = '0;
        t0  = '0;
        t1  = '0;
        case (r_m.op)
            OP_ADD: begin
                t0 = sx(r_m.ar) + sx(r_m.br);
                t1 = sx(r_m.ai) + sx(r_m.bi);
            end
            OP_SUB: begin
                t0 = sx(r_m.ar) - sx(r_m.br);
                t1 = sx(r_m.ai) - sx(r_m.bi);
            end
            OP_MUL: begin
                t0 = (px(r_m.p0) - px(r_m.p1)) >>> FB;
                t1 = (px(r_m.p2) + px(r_m.p3)) >>> FB;
            end
            OP_CNJ: begin
                t0 = sx(r_m.ar);
                t1 = -sx(r_m.ai);
            end
            OP_SQM: begin
                t0 = (px(r_m.p4) + px(r_m.p5)) >>> FB;
            end
            default: begin
            end
        endcase
        sr = sat_w(t0);
        si = sat_w(t1);
        s_n.re = sr[DW-1:0];
        s_n.im = si[DW-1:0];
        s_n.sf = sr[DW] | si[DW];
        s_n.eq = r_m.eq;
        if (r_m.op == OP_DIV) begin
            nre    = px(r_m.p0) + px(r_m.p1);
            nim    = px(r_m.p2) - px(r_m.p3);
            s_n.d  = r_m.p4[PW-1:0] + r_m.p5[PW-1:0];
            s_n.re = '0;
            s_n.im = '0;
            s_n.sf = 1'b0;
            if (s_n.d == '0) begin
                s_n.dz = 1'b1;
            end else begin
                s_n.isdiv = 1'b1;
                s_n.negr  = nre[SW-1];
                s_n.negi  = nim[SW-1];
                t0        = nre[SW-1] ? -nre : nre;
                t1        = nim[SW-1] ? -nim : nim;
                s_n.rr    = {t0[PW-1:0], {FB{1'b0}}};
                s_n.ri    = {t1[PW-1:0], {FB{1'b0}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_ds[0] <= s_n;
    end

    // restoring divider, one quotient bit of each part per stage
    for (genvar g = 0; g < QB; g++) begin : g_div
        t_ds           s_in, s_out;
        logic [CW-1:0] dsh;
        always_comb begin
            s_in  = r_ds[g];
            s_out = s_in;
            dsh   = CW'(s_in.d) << (QB - 1 - g);
            if ({{(CW-NW){1'b0}}, s_in.rr} >= dsh) begin
                s_out.rr            = s_in.rr - dsh[NW-1:0];
                s_out.qr[QB-1-g]    = 1'b1;
            end
            if ({{(CW-NW){1'b0}}, s_in.ri} >= dsh) begin
                s_out.ri            = s_in.ri - dsh[NW-1:0];
                s_out.qi[QB-1-g]    = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) r_ds[g+1] <= s_out;
        end
    end

    // output stage
    logic [DW:0] fr, fi;
    assign fr = fin(r_ds[QB].qr, r_ds[QB].negr);
    assign fi = fin(r_ds[QB].qi, r_ds[QB].negi);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_ds[QB].isdiv) begin
                r_fre <= fr[DW-1:0];
                r_fim <= fi[DW-1:0];
                r_fsf <= fr[DW] | fi[DW];
            end else begin
                r_fre <= r_ds[QB].re;
                r_fim <= r_ds[QB].im;
                r_fsf <= r_ds[QB].sf;
            end
            r_feq <= r_ds[QB].eq;
            r_fdz <= r_ds[QB].dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_dv <= '0;
            r_fv <= 1'b0;
        end else if (adv) begin
            r_mv <= i_valid;
            r_dv <= {r_dv[QB-1:0], r_mv};
            r_fv <= r_dv[QB];
        end
    end

    assign o_empty       = !r_fv;
    assign o_res_real    = r_fre;
    assign o_res_imag    = r_fim;
    assign o_is_equal    = r_feq;
    assign o_saturated   = r_fsf;
    assign o_div_by_zero = r_fdz;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv && r_fdz |-> r_fre == '0 && r_fim == '0 && !r_fsf)
        else $error("zero divisor result not cleared");
    a_eq_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv && r_feq |-> !r_fdz && !r_fsf && r_fim == '0)
        else $error("equality result carries other flags");
    a_take_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv && !i_pop |=> r_fv && $stable(r_fre))
        else $error("result lost while stalled");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import cau_pkg::*;

    // one operand transaction as offered to the block
    typedef struct {
        logic [2:0]           op;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
        bit                   drain;   // hold until every result is back
    } t_cplx_req;

    // result transaction the block should produce
    typedef struct {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 eq;
        logic                 sat;
        logic                 dz;
    } t_cplx_res;

    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE  = 1 <<< FB;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_push;
    logic                 o_full;
    logic [2:0]           i_req_type;
    logic signed [DW-1:0] i_a_real;
    logic signed [DW-1:0] i_a_imag;
    logic signed [DW-1:0] i_b_real;
    logic signed [DW-1:0] i_b_imag;
    logic                 o_empty;
    logic                 i_pop;
    logic signed [DW-1:0] o_res_real;
    logic signed [DW-1:0] o_res_imag;
    logic                 o_is_equal;
    logic                 o_saturated;
    logic                 o_div_by_zero;

    t_cplx_req pending_reqs[$];
    t_cplx_res expected_results[$];
    int        n_errors = 0;
    int        n_sent = 0;
    int        n_checked = 0;
    int        op_seen[8];
    int        tx_gap = 0;
    int        rx_gap = 0;
    int        rx_hold = 0;
    bit        rx_hold_done = 1'b0;
    bit        full_seen = 1'b0;

    complex_arithmetic_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_req_type    (i_req_type),
        .i_a_real      (i_a_real),
        .i_a_imag      (i_a_imag),
        .i_b_real      (i_b_real),
        .i_b_imag      (i_b_imag),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_res_real    (o_res_real),
        .o_res_imag    (o_res_imag),
        .o_is_equal    (o_is_equal),
        .o_saturated   (o_saturated),
        .o_div_by_zero (o_div_by_zero)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // clip an exact wide value to the data range, raising the flag on overflow
    function automatic logic signed [DW-1:0] clip(input logic signed [127:0] v, inout logic f);
        if (v > 128'(VMAX)) begin
            f = 1'b1;
            return VMAX;
        end
        if (v < 128'(VMIN)) begin
            f = 1'b1;
            return VMIN;
        end
        return v[DW-1:0];
    endfunction

    // scaled quotient, truncated toward zero
    function automatic logic signed [DW-1:0] fx_quot(input logic signed [127:0] n,
                                                   input logic signed [127:0] d,
                                                   inout logic f);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (n < 0) ? -n : n;
        q   = (mag <<< FB) / d;
        return clip((n < 0) ? -q : q, f);
    endfunction

    // exact 128-bit arithmetic for one transaction
    function automatic t_cplx_res complex_result(input t_cplx_req t);
        t_cplx_res           r;
        logic signed [127:0] xr, xi, yr, yi, d;
        logic                f;
        xr = 128'(t.ar);
        xi = 128'(t.ai);
        yr = 128'(t.br);
        yi = 128'(t.bi);
        f  = 1'b0;
        r  = '{re: '0, im: '0, eq: 1'b0, sat: 1'b0, dz: 1'b0};
        case (t.op)
            OP_ADD: begin
                r.re = clip(xr + yr, f);
                r.im = clip(xi + yi, f);
            end
            OP_SUB: begin
                r.re = clip(xr - yr, f);
                r.im = clip(xi - yi, f);
            end
            OP_MUL: begin
                r.re = clip((xr * yr - xi * yi) >>> FB, f);
                r.im = clip((xi * yr + xr * yi) >>> FB, f);
            end
            OP_DIV: begin
                d = yr * yr + yi * yi;
                if (d == 0) begin
                    r.dz = 1'b1;
                end else begin
                    // dividend is a times the conjugate of b, each part over the squared magnitude of b
                    r.re = fx_quot(xr * yr + xi * yi, d, f);
                    r.im = fx_quot(xi * yr - xr * yi, d, f);
                end
            end
            OP_CNJ: begin
                r.re = t.ar;
                r.im = clip(-xi, f);
            end
            OP_SQM: begin
                r.re = clip((xr * xr + xi * xi) >>> FB, f);
            end
            OP_EQ: begin
                r.eq = (t.ar == t.br) && (t.ai == t.bi);
            end
            default: begin
            end
        endcase
        r.sat = f;
        return r;
    endfunction

    // operand value biased toward edges and small magnitudes
    function automatic logic signed [DW-1:0] pick_val();
        case ($urandom_range(0, 9))
            0: return VMAX;
            1: return VMIN;
            2: return '0;
            3: return $urandom_range(0, 3);
            4, 5: return $signed($urandom_range(0, 1 << (FB + 3))) - (1 << (FB + 2));
            default: return $urandom;
        endcase
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input int phase);
        int r;
        if (phase % 4 == 0) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic add_req(input logic [2:0] op, input logic signed [DW-1:0] ar,
                           input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
                           input logic signed [DW-1:0] bi, input bit drain);
        pending_reqs.push_back('{op: op, ar: ar, ai: ai, br: br, bi: bi, drain: drain});
    endtask

    // driver: offers the queued transactions, records the expectation on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                expected_results.push_back(complex_result('{op: i_req_type, ar: i_a_real,
                    ai: i_a_imag, br: i_b_real, bi: i_b_imag, drain: 1'b0}));
                op_seen[i_req_type]++;
                n_sent++;
                tx_gap = pick_gap(n_sent / 100 + 1);
            end
            if (i_push && o_full) begin
                full_seen = 1'b1;
                i_push <= 1'b1;  // keep offering the same transaction
            end else if (tx_gap > 0) begin
                tx_gap--;
                i_push <= 1'b0;
            end else if (pending_reqs.size() > 0 && !(pending_reqs[0].drain &&
                         (expected_results.size() > 0 || i_push))) begin
                i_req_type <= pending_reqs[0].op;
                i_a_real   <= pending_reqs[0].ar;
                i_a_imag   <= pending_reqs[0].ai;
                i_b_real   <= pending_reqs[0].br;
                i_b_imag   <= pending_reqs[0].bi;
                i_push     <= 1'b1;
                void'(pending_reqs.pop_front());
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // monitor: compares each popped result with the oldest expectation
    always @(posedge i_clk) begin
        t_cplx_res e;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result re=%h im=%h", $time, o_res_real,
                             o_res_imag);
                    n_errors++;
                end else begin
                    e = expected_results.pop_front();
                    n_checked++;
                    if (o_res_real !== e.re || o_res_imag !== e.im || o_is_equal !== e.eq ||
                        o_saturated !== e.sat || o_div_by_zero !== e.dz) begin
                        $display("%0t: mismatch expected re=%h im=%h eq=%b sat=%b dz=%b",
                                 $time, e.re, e.im, e.eq, e.sat, e.dz);
                        $display("%0t:          actual   re=%h im=%h eq=%b sat=%b dz=%b",
                                 $time, o_res_real, o_res_imag, o_is_equal, o_saturated,
                                 o_div_by_zero);
                        n_errors++;
                    end
                end
                rx_gap = pick_gap(n_checked / 100 + 2);
            end
            // one long hold-off mid-run so the block fills and stalls its input
            if (!rx_hold_done && n_checked >= 500) begin
                rx_hold_done = 1'b1;
                rx_hold = 300;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_push     = 1'b0;
        i_pop      = 1'b0;
        i_req_type = OP_ADD;
        i_a_real   = '0;
        i_a_imag   = '0;
        i_b_real   = '0;
        i_b_imag   = '0;

        // directed: range edges, every operation and the corner cases
        add_req(OP_ADD, VMAX, VMIN, VMAX, VMIN, 1'b0);
        add_req(OP_ADD, '0, '0, '0, '0, 1'b0);
        add_req(OP_SUB, VMIN, VMAX, VMAX, VMIN, 1'b0);
        add_req(OP_SUB, ONE, -ONE, ONE, ONE, 1'b0);
        add_req(OP_MUL, VMIN, VMIN, VMIN, VMIN, 1'b0);
        add_req(OP_MUL, -1, 3, 1, -5, 1'b0);
        add_req(OP_MUL, ONE, ONE, -ONE, ONE, 1'b0);
        add_req(OP_DIV, ONE, ONE, '0, '0, 1'b0);
        add_req(OP_DIV, VMAX, VMIN, 1, '0, 1'b0);
        add_req(OP_DIV, -ONE, 3, '0, 1, 1'b0);
        add_req(OP_DIV, 7 * ONE, -ONE, 2 * ONE, -3 * ONE, 1'b0);
        add_req(OP_DIV, VMIN, VMIN, VMIN, VMIN, 1'b0);
        add_req(OP_CNJ, VMAX, VMIN, '0, '0, 1'b0);
        add_req(OP_CNJ, VMIN, VMAX, '1, '1, 1'b0);
        add_req(OP_SQM, VMAX, VMAX, '0, '0, 1'b0);
        add_req(OP_SQM, -1, 1, '0, '0, 1'b0);
        add_req(OP_EQ, ONE, -ONE, ONE, -ONE, 1'b0);
        add_req(OP_EQ, ONE, -ONE, ONE, ONE, 1'b0);
        add_req(OP_EQ, VMIN, VMAX, VMIN, VMAX, 1'b0);
        add_req(3'd7, VMAX, VMIN, VMAX, VMIN, 1'b0);

        // random: equality gets matching operands half the time
        for (int k = 0; k < 830; k++) begin
            logic [2:0]           op;
            logic signed [DW-1:0] ar, ai, br, bi;
            op = (k % 97 == 0) ? 3'd7 : 3'($urandom_range(0, 6));
            ar = pick_val();
            ai = pick_val();
            br = pick_val();
            bi = pick_val();
            if (op == OP_EQ && $urandom_range(0, 1)) begin
                br = ar;
                bi = (k % 5 == 0) ? ai ^ (1 << $urandom_range(0, DW - 1)) : ai;
            end
            // sender pauses until the block has drained, once early and once late
            add_req(op, ar, ai, br, bi, k == 0 || k == 400);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        wait (!i_push && expected_results.size() == 0);
        repeat (60) @(posedge i_clk);

        $display("%0d transactions sent, %0d results checked, input stalled by full: %0d",
                 n_sent, n_checked, full_seen);
        $display("per operation add..unused: %0d %0d %0d %0d %0d %0d %0d %0d", op_seen[0],
                 op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5], op_seen[6],
                 op_seen[7]);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule
